// ===== src/mwp_pkg.sv =====
package mwp_pkg;

    // Result kinds carried in the kind field of a result word.
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    // Error codes reported with an error result.
    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_RIFF     = 4'd1,
        ERR_WAVE     = 4'd2,
        ERR_FMT_TAG  = 4'd3,
        ERR_FMT_SIZE = 4'd4,
        ERR_NOT_PCM  = 4'd5,
        ERR_NOT_MONO = 4'd6,
        ERR_DATA_TAG = 4'd7,
        ERR_BAD_BITS = 4'd8
    } err_code_t;

    // Chunk tags, first file byte in the low lane.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [7:0] FMT_CHUNK_SIZE = 8'd16;
    localparam logic [7:0] PCM_OFFSET     = 8'h80;

    localparam int unsigned MAX_SAMPLE_BITS = 32;

    // Header geometry.
    localparam int unsigned POS_W       = 6;
    localparam logic [POS_W-1:0] HEADER_LAST = 6'd43;

    // Division by three is a multiplication by (2^33 + 1) / 3 and a shift by 33.
    localparam logic [31:0] RECIP_THREE = 32'hAAAA_AAAB;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      clear;
        logic      hdr_take;
        logic      div_start;
        logic      div_step;
        logic      smp_take;
        logic      emit;
        kind_t     emit_kind;
        err_code_t emit_code;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        err_code_t hdr_code;
        logic      hdr_last;
        logic      bits_ok;
        logic      smp_full;
        logic      cnt_one;
        logic      cnt_zero;
        logic      out_busy;
        logic      restart;
    } sts_t;

endpackage

// ===== src/mwp_in_if.sv =====
interface mwp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       restart;

    modport source (output valid, output file_byte, output restart, input ready);
    modport sink (input valid, input file_byte, input restart, output ready);

endinterface

// ===== src/mwp_out_if.sv =====
interface mwp_out_if
    import mwp_pkg::*;
    ;

    logic               valid;
    logic               ready;
    kind_t              kind;
    err_code_t          error_code;
    logic signed [31:0] sample_value;
    logic [31:0]        sample_rate;
    logic [7:0]         bits_per_sample;
    logic [31:0]        sample_count;
    logic               last_sample;

    modport source (
        output valid, output kind, output error_code, output sample_value,
        output sample_rate, output bits_per_sample, output sample_count,
        output last_sample, input ready
    );
    modport sink (
        input valid, input kind, input error_code, input sample_value,
        input sample_rate, input bits_per_sample, input sample_count,
        input last_sample, output ready
    );

endinterface

// ===== src/mwp_ctrl.sv =====
module mwp_ctrl
    import mwp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_HEADER  = 5'b00001,
        ST_DIVIDE  = 5'b00010,
        ST_HDR_OUT = 5'b00100,
        ST_SAMPLES = 5'b01000,
        ST_IDLE    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   in_header;

    // A byte is taken unless the divider runs, the header result waits,
    // or the result register still holds an unread word.
    assign in_ready = (state_reg != ST_DIVIDE) && (state_reg != ST_HDR_OUT) && !sts.out_busy;
    assign accept   = in_valid && in_ready;

    // A restart byte is always parsed as the first header byte.
    assign in_header = sts.restart || (state_reg == ST_HEADER);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit_kind = KIND_HEADER;
        cmd.emit_code = ERR_NONE;
        unique case (state_reg)
            ST_HEADER, ST_SAMPLES, ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.clear = sts.restart;
                    if (in_header)
                    begin
                        state_next = ST_HEADER;
                        if (sts.hdr_code != ERR_NONE)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_ERROR;
                            cmd.emit_code = sts.hdr_code;
                            state_next    = ST_IDLE;
                        end
                        else if (sts.hdr_last && !sts.bits_ok)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_ERROR;
                            cmd.emit_code = ERR_BAD_BITS;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            cmd.hdr_take = 1'b1;
                            if (sts.hdr_last)
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = ST_DIVIDE;
                            end
                        end
                    end
                    else if (state_reg == ST_SAMPLES)
                    begin
                        cmd.smp_take = 1'b1;
                        if (sts.smp_full)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_SAMPLE;
                            if (sts.cnt_one)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_HDR_OUT;
            end
            ST_HDR_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_HEADER;
                    state_next    = sts.cnt_zero ? ST_IDLE : ST_SAMPLES;
                end
            end
            default:
            begin
                state_next = ST_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/mwp_dp.sv =====
module mwp_dp
    import mwp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] file_byte,
    input  logic       restart,
    input  cmd_t       cmd,
    output sts_t       sts,
    mwp_out_if.source  result
);

    logic [POS_W-1:0]     pos_reg;
    logic [31:0]          rate_reg;
    logic [7:0]           bits_reg;
    logic [31:0]          remain_reg;
    logic [23:0]          asm_reg;
    logic [1:0]           bis_reg;
    logic                 out_valid_reg;

    logic [POS_W-1:0] pos_eff;
    err_code_t        hdr_code;
    logic [2:0]       nbytes;
    logic [63:0]      third_prod;
    logic [31:0]      quotient;
    logic [31:0]      raw;
    logic [31:0]      value;
    logic [7:0]       tag_byte;
    logic [31:0]      out_value_next;
    logic [31:0]      out_rate_next;
    logic [7:0]       out_bits_next;
    logic [31:0]      out_count_next;
    logic             out_last_next;

    // The restart byte is checked as header byte zero.
    assign pos_eff = restart ? '0 : pos_reg;
    assign nbytes  = bits_reg[5:3];

    // Header byte checks.
    always_comb
    begin
        hdr_code = ERR_NONE;
        tag_byte = '0;
        case (pos_eff) inside
            [6'd0:6'd3]:
            begin
                tag_byte = TAG_RIFF[8*pos_eff[1:0] +: 8];
                if (file_byte != tag_byte) hdr_code = ERR_RIFF;
            end
            [6'd8:6'd11]:
            begin
                tag_byte = TAG_WAVE[8*pos_eff[1:0] +: 8];
                if (file_byte != tag_byte) hdr_code = ERR_WAVE;
            end
            [6'd12:6'd15]:
            begin
                tag_byte = TAG_FMT[8*pos_eff[1:0] +: 8];
                if (file_byte != tag_byte) hdr_code = ERR_FMT_TAG;
            end
            6'd16:
            begin
                if (file_byte != FMT_CHUNK_SIZE) hdr_code = ERR_FMT_SIZE;
            end
            [6'd17:6'd19]:
            begin
                if (file_byte != 8'd0) hdr_code = ERR_FMT_SIZE;
            end
            6'd20, 6'd21:
            begin
                if (file_byte != {7'd0, ~pos_eff[0]}) hdr_code = ERR_NOT_PCM;
            end
            6'd22, 6'd23:
            begin
                if (file_byte != {7'd0, ~pos_eff[0]}) hdr_code = ERR_NOT_MONO;
            end
            [6'd36:6'd39]:
            begin
                tag_byte = TAG_DATA[8*pos_eff[1:0] +: 8];
                if (file_byte != tag_byte) hdr_code = ERR_DATA_TAG;
            end
            default:
            begin
                hdr_code = ERR_NONE;
            end
        endcase
    end

    // Sample count: a shift for one, two or four bytes a sample,
    // a multiplication by the reciprocal for three.
    assign third_prod = {32'd0, remain_reg} * {32'd0, RECIP_THREE};

    always_comb
    begin
        case (nbytes)
            3'd1:    quotient = remain_reg;
            3'd2:    quotient = {1'b0, remain_reg[31:1]};
            3'd3:    quotient = {1'b0, third_prod[63:33]};
            default: quotient = {2'b0, remain_reg[31:2]};
        endcase
    end

    // Sample assembly with the current byte in its lane.
    always_comb
    begin
        raw = {8'd0, asm_reg};
        case (bis_reg)
            2'd0:    raw[7:0]   = file_byte;
            2'd1:    raw[15:8]  = file_byte;
            2'd2:    raw[23:16] = file_byte;
            default: raw[31:24] = file_byte;
        endcase
        case (nbytes)
            3'd1:    value = {{24{~raw[7]}}, raw[7:0] ^ PCM_OFFSET};
            3'd2:    value = {{16{raw[15]}}, raw[15:0]};
            3'd3:    value = {{8{raw[23]}}, raw[23:0]};
            default: value = raw;
        endcase
    end

    // Status to the controller.
    always_comb
    begin
        sts.hdr_code = hdr_code;
        sts.hdr_last = (pos_eff == HEADER_LAST);
        sts.bits_ok  = ((bits_reg == 8'd8) || (bits_reg == 8'd16) || (bits_reg == 8'd24)
                        || (bits_reg == 8'd32)) && (32'(bits_reg) <= MAX_SAMPLE_BITS);
        sts.smp_full = ({1'b0, bis_reg} + 3'd1) >= nbytes;
        sts.cnt_one  = (remain_reg == 32'd1);
        sts.cnt_zero = (remain_reg == 32'd0);
        sts.out_busy = out_valid_reg && !result.ready;
        sts.restart  = restart;
    end

    // Header position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.hdr_take)
        begin
            pos_reg <= pos_eff + POS_W'(1);
        end
        else if (cmd.clear)
        begin
            pos_reg <= '0;
        end
    end

    // Captured header fields and the sample count.
    always_ff @(posedge clk)
    begin
        if (cmd.hdr_take)
        begin
            case (pos_eff) inside
                [6'd24:6'd27]: rate_reg[8*pos_eff[1:0] +: 8]   <= file_byte;
                6'd34:         bits_reg                         <= file_byte;
                [6'd40:6'd43]: remain_reg[8*pos_eff[1:0] +: 8] <= file_byte;
                default:       rate_reg                         <= rate_reg;
            endcase
        end
        if (cmd.div_step)
        begin
            remain_reg <= quotient;
        end
        else if (cmd.smp_take && sts.smp_full)
        begin
            remain_reg <= remain_reg - 32'd1;
        end
    end

    // Sample byte gathering.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_reg <= '0;
            bis_reg <= '0;
        end
        else if (cmd.clear || cmd.div_start || (cmd.smp_take && sts.smp_full))
        begin
            asm_reg <= '0;
            bis_reg <= '0;
        end
        else if (cmd.smp_take)
        begin
            asm_reg <= raw[23:0];
            bis_reg <= bis_reg + 2'd1;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Fields of the next result word; those a kind does not use are zero.
    always_comb
    begin
        out_value_next = '0;
        out_rate_next  = '0;
        out_bits_next  = '0;
        out_count_next = '0;
        out_last_next  = 1'b0;
        case (cmd.emit_kind)
            KIND_HEADER:
            begin
                out_rate_next  = rate_reg;
                out_bits_next  = bits_reg;
                out_count_next = remain_reg;
                out_last_next  = sts.cnt_zero;
            end
            KIND_SAMPLE:
            begin
                out_value_next = value;
                out_last_next  = sts.cnt_one;
            end
            default:
            begin
                out_last_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result.kind            <= cmd.emit_kind;
            result.error_code      <= cmd.emit_code;
            result.sample_value    <= out_value_next;
            result.sample_rate     <= out_rate_next;
            result.bits_per_sample <= out_bits_next;
            result.sample_count    <= out_count_next;
            result.last_sample     <= out_last_next;
        end
    end

    assign result.valid = out_valid_reg;

endmodule

// ===== src/mono_pcm_wav_stream_parser_core.sv =====
// Channel   Direction  Interface   Word
// data_in   in         mwp_in_if   file_byte, restart
// result    out        mwp_out_if  kind, error_code, sample fields, header fields
//
// Header and sample bytes are taken at one a cycle, but none during the division and header result.
// After the last header byte the parser divides the data size by the bytes per sample
// (a shift, or a multiplication by the reciprocal of three) and then gives the header
// result, which waits while the result register holds a word the receiver does not take.
// Reset (rst_n, asynchronous) leaves the parser waiting for header byte zero.
// A byte is held off while the result register holds a word the receiver does not take.
module mono_pcm_wav_stream_parser_core
    import mwp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mwp_in_if.sink    data_in,
    mwp_out_if.source result
);

    cmd_t cmd;
    sts_t sts;

    // Sequencing of header, division and sample phases.
    mwp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (data_in.valid),
        .in_ready (data_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Checks, captures, sample count, sample assembly and result register.
    mwp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .file_byte (data_in.file_byte),
        .restart   (data_in.restart),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

endmodule

// ===== tb/mwp_parser_checker.sv =====
module mwp_parser_checker
    import mwp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mwp_in_if    in_mon,
    mwp_out_if   res_mon,
    output int   fail_count,
    output int   pending
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SAMPLES,
        PH_DONE,
        PH_FAULT
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        err_code_t   code;
        logic [31:0] value;
        logic [31:0] rate;
        logic [7:0]  bits;
        logic [31:0] count;
        logic        last;
    } parse_result_t;

    // Shadow copy of the parser state.
    logic [5:0]  hdr_pos;
    logic [31:0] rate_acc;
    logic [7:0]  depth;
    logic [31:0] remaining;
    logic [31:0] assembly;
    logic [1:0]  byte_idx;
    phase_t      phase;

    parse_result_t due_results[$];
    parse_result_t predicted;
    parse_result_t seen;
    int            mismatches = 0;

    function void clear_parse;
        hdr_pos   = '0;
        rate_acc  = '0;
        depth     = '0;
        remaining = '0;
        assembly  = '0;
        byte_idx  = '0;
        phase     = PH_HEADER;
    endfunction

    // Works out what one accepted byte produces; returns 1 when a word is due.
    function automatic bit predict_parse(input logic [7:0] b, input logic rs,
                                         output parse_result_t r);
        logic [5:0]  p;
        err_code_t   code;
        logic [31:0] quo;
        logic [2:0]  nbytes;
        r = '0;
        if (rs)
            clear_parse();
        case (phase)
            PH_HEADER:
            begin
                p    = hdr_pos;
                code = ERR_NONE;
                if (p <= 6'd3)
                begin
                    if (b != TAG_RIFF[8*p +: 8]) code = ERR_RIFF;
                end
                else if (p >= 6'd8 && p <= 6'd11)
                begin
                    if (b != TAG_WAVE[8*(p-8) +: 8]) code = ERR_WAVE;
                end
                else if (p >= 6'd12 && p <= 6'd15)
                begin
                    if (b != TAG_FMT[8*(p-12) +: 8]) code = ERR_FMT_TAG;
                end
                else if (p == 6'd16)
                begin
                    if (b != FMT_CHUNK_SIZE) code = ERR_FMT_SIZE;
                end
                else if (p >= 6'd17 && p <= 6'd19)
                begin
                    if (b != 8'd0) code = ERR_FMT_SIZE;
                end
                else if (p == 6'd20)
                begin
                    if (b != 8'd1) code = ERR_NOT_PCM;
                end
                else if (p == 6'd21)
                begin
                    if (b != 8'd0) code = ERR_NOT_PCM;
                end
                else if (p == 6'd22)
                begin
                    if (b != 8'd1) code = ERR_NOT_MONO;
                end
                else if (p == 6'd23)
                begin
                    if (b != 8'd0) code = ERR_NOT_MONO;
                end
                else if (p >= 6'd24 && p <= 6'd27)
                begin
                    if (p == 6'd24) rate_acc = '0;
                    rate_acc[8*(p-24) +: 8] = b;
                end
                else if (p == 6'd34)
                begin
                    depth = b;
                end
                else if (p >= 6'd36 && p <= 6'd39)
                begin
                    if (b != TAG_DATA[8*(p-36) +: 8]) code = ERR_DATA_TAG;
                end
                else if (p >= 6'd40 && p <= 6'd43)
                begin
                    if (p == 6'd40) remaining = '0;
                    remaining[8*(p-40) +: 8] = b;
                end

                if (code != ERR_NONE)
                begin
                    phase  = PH_FAULT;
                    r.kind = KIND_ERROR;
                    r.code = code;
                    return 1'b1;
                end

                if (p == HEADER_LAST)
                begin
                    // Only whole-byte depths up to the widest sample are usable.
                    if (!(depth == 8'd8 || depth == 8'd16 || depth == 8'd24
                          || depth == 8'd32) || depth > MAX_SAMPLE_BITS)
                    begin
                        phase  = PH_FAULT;
                        r.kind = KIND_ERROR;
                        r.code = ERR_BAD_BITS;
                        return 1'b1;
                    end
                    quo       = remaining / {27'd0, depth[7:3]};
                    remaining = quo;
                    assembly  = '0;
                    byte_idx  = '0;
                    phase     = (quo != 0) ? PH_SAMPLES : PH_DONE;
                    r.kind    = KIND_HEADER;
                    r.code    = ERR_NONE;
                    r.rate    = rate_acc;
                    r.bits    = depth;
                    r.count   = quo;
                    r.last    = (quo == 0);
                    return 1'b1;
                end
                hdr_pos = p + 6'd1;
                return 1'b0;
            end

            PH_SAMPLES:
            begin
                nbytes = depth[5:3];
                assembly[8*byte_idx +: 8] = b;
                if (int'(byte_idx) + 1 < int'(nbytes))
                begin
                    byte_idx = byte_idx + 2'd1;
                    return 1'b0;
                end
                // Eight-bit data is offset binary; wider data is two's complement.
                case (nbytes)
                    3'd1: r.value = {24'd0, assembly[7:0]} - {24'd0, PCM_OFFSET};
                    3'd2: r.value = {{16{assembly[15]}}, assembly[15:0]};
                    3'd3: r.value = {{8{assembly[23]}}, assembly[23:0]};
                    default: r.value = assembly;
                endcase
                assembly  = '0;
                byte_idx  = '0;
                remaining = remaining - 32'd1;
                r.kind    = KIND_SAMPLE;
                r.code    = ERR_NONE;
                r.last    = (remaining == 0);
                if (remaining == 0)
                    phase = PH_DONE;
                return 1'b1;
            end

            default: return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    // Predict on every accepted byte, compare every accepted result word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            due_results.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
            begin
                if (predict_parse(in_mon.file_byte, in_mon.restart, predicted))
                    due_results.push_back(predicted);
            end

            if (res_mon.valid && res_mon.ready)
            begin
                seen.kind  = res_mon.kind;
                seen.code  = res_mon.error_code;
                seen.value = res_mon.sample_value;
                seen.rate  = res_mon.sample_rate;
                seen.bits  = res_mon.bits_per_sample;
                seen.count = res_mon.sample_count;
                seen.last  = res_mon.last_sample;
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: kind %0d code %0d value %0h",
                                 seen.kind, seen.code, seen.value);
                end
                else
                begin
                    predicted = due_results.pop_front();
                    check_field("kind", 32'(predicted.kind), 32'(seen.kind));
                    check_field("error_code", 32'(predicted.code), 32'(seen.code));
                    check_field("sample_value", predicted.value, seen.value);
                    check_field("sample_rate", predicted.rate, seen.rate);
                    check_field("bits_per_sample", 32'(predicted.bits), 32'(seen.bits));
                    check_field("sample_count", predicted.count, seen.count);
                    check_field("last_sample", 32'(predicted.last), 32'(seen.last));
                end
            end

            pending    <= due_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== tb/tb_mono_pcm_wav_stream_parser_core.sv =====
module tb_mono_pcm_wav_stream_parser_core
    import mwp_pkg::*;
    ;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TOTAL_BYTES = 1650;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   burst_left = 0;
    bit   calm = 1'b0;
    int   sent = 0;

    logic [7:0] file_bytes[$];

    mwp_in_if  data_in();
    mwp_out_if result();

    mono_pcm_wav_stream_parser_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .data_in (data_in),
        .result  (result)
    );

    mwp_parser_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (data_in),
        .res_mon    (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_mono_pcm_wav_stream_parser_core: done, errors");
            $finish;
        end
    end

    // The receiver switches at random between stall patterns.
    initial
    begin
        int mode;
        int count;
        mode  = 0;
        count = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            count++;
            if (count % 300 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: result.ready <= 1'b1;
                1: result.ready <= ($urandom_range(0, 1) == 1);
                2: result.ready <= ($urandom_range(0, 3) == 0);
                default: result.ready <= count[3];
            endcase
        end
    end

    // One byte on the input channel; the sender may idle between bursts.
    task automatic send_word(input logic [7:0] b, input logic rs);
        int   gap;
        logic took;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = calm ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                data_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        data_in.valid     <= 1'b1;
        data_in.file_byte <= b;
        data_in.restart   <= rs;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = data_in.ready;
            @(posedge clk);
        end
        burst_left--;
        sent++;
    endtask

    // Builds a well-formed header; unchecked bytes get random filler.
    task automatic start_file(input logic [31:0] rate, input logic [7:0] bits,
                              input logic [31:0] size);
        file_bytes.delete();
        for (int i = 0; i < 44; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
        for (int k = 0; k < 4; k++)
        begin
            file_bytes[k]      = TAG_RIFF[8*k +: 8];
            file_bytes[8 + k]  = TAG_WAVE[8*k +: 8];
            file_bytes[12 + k] = TAG_FMT[8*k +: 8];
            file_bytes[24 + k] = rate[8*k +: 8];
            file_bytes[36 + k] = TAG_DATA[8*k +: 8];
            file_bytes[40 + k] = size[8*k +: 8];
        end
        file_bytes[16] = FMT_CHUNK_SIZE;
        file_bytes[17] = 8'd0;
        file_bytes[18] = 8'd0;
        file_bytes[19] = 8'd0;
        file_bytes[20] = 8'd1;
        file_bytes[21] = 8'd0;
        file_bytes[22] = 8'd1;
        file_bytes[23] = 8'd0;
        file_bytes[34] = bits;
    endtask

    task automatic add_bytes(input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic corrupt_at(input int pos);
        file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(1, 255));
    endtask

    task automatic send_file(input logic rs);
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < file_bytes.size(); i++)
            send_word(file_bytes[i], (i == 0) ? rs : 1'b0);
    endtask

    // Holds the sender off until every predicted word has come back.
    task automatic drain;
        data_in.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int         err_pos[7];
        logic [7:0] bad_depth[3];
        int         choice;
        int         k;
        logic [7:0] depth;
        logic [31:0] size;
        bit         pressed;

        err_pos   = '{0, 9, 14, 17, 20, 23, 38};
        bad_depth = '{8'd12, 8'd0, 8'd40};
        pressed   = 1'b0;

        rst_n             <= 1'b0;
        data_in.valid     <= 1'b0;
        data_in.file_byte <= 8'd0;
        data_in.restart   <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First file straight after reset, without a restart flag.
        start_file(32'd44100, 8'd16, 32'd6);
        file_bytes.push_back(8'hFF); file_bytes.push_back(8'h7F);
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h80);
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h00);
        add_bytes(3);
        send_file(1'b0);

        // Eight-bit extremes, stored with the offset.
        start_file(32'd8000, 8'd8, 32'd3);
        file_bytes.push_back(8'h00); file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h80);
        send_file(1'b1);

        // 24-bit extremes, with one odd byte left over in the data size.
        start_file(32'd96000, 8'd24, 32'd7);
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h80); file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF); file_bytes.push_back(8'h7F);
        add_bytes(1);
        send_file(1'b1);

        // 32-bit extremes and the largest rate.
        start_file(32'hFFFF_FFFF, 8'd32, 32'd8);
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h80);
        file_bytes.push_back(8'hFF); file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF); file_bytes.push_back(8'h7F);
        send_file(1'b1);

        // Empty data chunk, and a data chunk shorter than one sample.
        start_file(32'd0, 8'd16, 32'd0);
        add_bytes(2);
        send_file(1'b1);
        start_file(32'd22050, 8'd16, 32'd1);
        add_bytes(2);
        send_file(1'b1);

        // Largest data size, cut short by the next restart.
        start_file(32'd48000, 8'd8, 32'hFFFF_FFFF);
        add_bytes(3);
        send_file(1'b1);

        // One failed check of each kind, with bytes after it that are ignored.
        for (int i = 0; i < 7; i++)
        begin
            start_file(32'd44100, 8'd16, 32'd4);
            corrupt_at(err_pos[i]);
            add_bytes(4);
            send_file(1'b1);
        end
        for (int i = 0; i < 3; i++)
        begin
            start_file(32'd44100, bad_depth[i], 32'd4);
            add_bytes(4);
            send_file(1'b1);
        end

        drain();
        @(posedge clk);

        // Random files: mostly well formed, some broken, some plain noise.
        while (sent < TOTAL_BYTES)
        begin
            if (!pressed && sent > TOTAL_BYTES / 2)
            begin
                drain();
                @(posedge clk);
                pressed = 1'b1;
            end
            choice = $urandom_range(0, 99);
            depth  = 8'(8 * $urandom_range(1, 4));
            if (choice < 60)
            begin
                size = $urandom_range(0, 48);
                start_file($urandom(), depth, size);
                add_bytes(size + $urandom_range(0, 3));
            end
            else if (choice < 65)
            begin
                // Header cut off part way by the next restart.
                start_file($urandom(), depth, $urandom_range(0, 48));
                k = $urandom_range(1, 43);
                while (file_bytes.size() > k)
                    void'(file_bytes.pop_back());
            end
            else if (choice < 75)
            begin
                start_file($urandom(), depth, $urandom());
                add_bytes($urandom_range(0, 30));
            end
            else if (choice < 90)
            begin
                start_file($urandom(), depth, $urandom_range(0, 16));
                k = $urandom_range(0, 23);
                if (k < 4)
                    corrupt_at(k);
                else if (k < 20)
                    corrupt_at(k + 4);
                else
                    corrupt_at(k + 16);
                add_bytes($urandom_range(0, 6));
            end
            else if (choice < 95)
            begin
                start_file($urandom(), 8'($urandom_range(0, 255)), $urandom_range(0, 16));
                add_bytes($urandom_range(0, 16));
            end
            else
            begin
                file_bytes.delete();
                add_bytes($urandom_range(1, 20));
            end

            if (choice >= 95)
            begin
                calm = 1'b0;
                for (int i = 0; i < file_bytes.size(); i++)
                    send_word(file_bytes[i], $urandom_range(0, 7) == 0);
            end
            else
            begin
                send_file(1'b1);
            end
        end

        // Let the last words come out, then allow for any stray ones.
        drain();
        repeat (64) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_mono_pcm_wav_stream_parser_core: done, clean");
        else
            $display("tb_mono_pcm_wav_stream_parser_core: done, errors");
        $finish;
    end

endmodule

// ===== mono_pcm_wav_stream_parser_core.f =====
src/mwp_pkg.sv
src/mwp_in_if.sv
src/mwp_out_if.sv
src/mwp_ctrl.sv
src/mwp_dp.sv
src/mono_pcm_wav_stream_parser_core.sv
tb/mwp_parser_checker.sv
tb/tb_mono_pcm_wav_stream_parser_core.sv
